>>> rtl/decimating_dc_blocking_filter_macros.svh
// Assertion macros used by the checker of the DC-blocking filter.
// No dependencies; include by bare file name.
`ifndef DECIMATING_DC_BLOCKING_FILTER_MACROS_SVH
`define DECIMATING_DC_BLOCKING_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dcb check failed");

// Next-cycle implication, disabled while reset is low.
`define DCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dcb check failed");

`endif

>>> rtl/dcb_pkg.sv
// Shared widths, constants, register indexes and types of the DC-blocking filter.
// No dependencies.
package dcb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 32;
  localparam int FACTOR_W   = 7;
  localparam int SHIFT_W    = 5;
  localparam int AMT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int COEF_W     = 17;
  localparam int PROD_W     = ACC_W + COEF_W;
  localparam int FRAC_W     = 16;

  // 0.995 as unsigned Q0.16, kept one bit wider so the multiply is signed
  localparam logic [COEF_W-1:0]         DCB_COEF     = 17'd65208;
  localparam logic signed [SHIFT_W-1:0] SHIFT_LIMIT  = 5'sd8;
  localparam logic [FACTOR_W-1:0]       FACTOR_RESET = 7'd1;
  localparam logic [SHIFT_W-1:0]        GAIN_RESET   = 5'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM = 2'd0,
    REG_GAIN  = 2'd1
  } cfg_reg_t;

  // Accumulator to filter: group closed this beat, and its scaled sum
  typedef struct packed {
    logic             close;
    logic [ACC_W-1:0] x;
  } dcb_group_t;

  // Filter result for the output register
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } dcb_result_t;

endpackage

>>> rtl/dcb_accum.sv
// Group accumulator: sums samples, closes a group at the decimation factor,
// applies the clamped gain shift. Depends on dcb_pkg.
module dcb_accum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic signed [dcb_pkg::SAMPLE_W-1:0]  sample,
  input  logic [dcb_pkg::FACTOR_W-1:0]         factor,
  input  logic signed [dcb_pkg::SHIFT_W-1:0]   gain,
  output dcb_pkg::dcb_group_t                  grp
);

  logic [dcb_pkg::ACC_W-1:0]    group_sum_r, group_sum_nxt;
  logic [dcb_pkg::FACTOR_W-1:0] group_count_r, group_count_nxt;
  logic [dcb_pkg::ACC_W-1:0]    sum_new;
  logic [dcb_pkg::FACTOR_W-1:0] count_new;
  logic [dcb_pkg::FACTOR_W-1:0] factor_eff;
  logic signed [dcb_pkg::SHIFT_W-1:0] gain_clamped;
  logic [dcb_pkg::AMT_W-1:0]    amt;
  logic                         close;

  assign sum_new   = group_sum_r + {{(dcb_pkg::ACC_W - dcb_pkg::SAMPLE_W){sample[dcb_pkg::SAMPLE_W-1]}},
                                    sample};
  assign count_new = group_count_r + dcb_pkg::FACTOR_W'(1);
  // A zero factor behaves as one
  assign factor_eff = (factor == '0) ? dcb_pkg::FACTOR_W'(1) : factor;
  assign close      = (count_new == '0) || (count_new >= factor_eff);

  always_comb begin
    if (gain > dcb_pkg::SHIFT_LIMIT) begin
      gain_clamped = dcb_pkg::SHIFT_LIMIT;
    end else if (gain < -dcb_pkg::SHIFT_LIMIT) begin
      gain_clamped = -dcb_pkg::SHIFT_LIMIT;
    end else begin
      gain_clamped = gain;
    end
  end

  assign amt = gain_clamped[dcb_pkg::SHIFT_W-1] ? dcb_pkg::AMT_W'(-gain_clamped)
                                                 : dcb_pkg::AMT_W'(gain_clamped);

  always_comb begin
    grp.close = close;
    if (gain_clamped[dcb_pkg::SHIFT_W-1]) begin
      grp.x = $unsigned($signed(sum_new) >>> amt);
    end else begin
      grp.x = sum_new << amt;
    end
  end

  always_comb begin
    group_sum_nxt   = group_sum_r;
    group_count_nxt = group_count_r;
    if (fire) begin
      group_sum_nxt   = close ? '0 : sum_new;
      group_count_nxt = close ? '0 : count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_sum_r   <= '0;
      group_count_r <= '0;
    end else begin
      group_sum_r   <= group_sum_nxt;
      group_count_r <= group_count_nxt;
    end
  end

endmodule

>>> rtl/dcb_filter.sv
// First-order DC-blocking high-pass with 16-bit saturation.
// Depends on dcb_pkg.
module dcb_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [dcb_pkg::ACC_W-1:0]    x,
  output dcb_pkg::dcb_result_t         res
);

  logic [dcb_pkg::ACC_W-1:0]         x_prev_r, x_prev_nxt;
  logic [dcb_pkg::ACC_W-1:0]         y_prev_r, y_prev_nxt;
  logic signed [dcb_pkg::PROD_W-1:0] prod;
  logic signed [dcb_pkg::PROD_W-1:0] prod_biased;
  logic [dcb_pkg::ACC_W-1:0]         fb;
  logic [dcb_pkg::ACC_W-1:0]         y;
  logic                              over, under;

  assign prod = $signed(y_prev_r) * $signed(dcb_pkg::DCB_COEF);
  // Bias negative products so the arithmetic shift truncates toward zero
  assign prod_biased = prod + (prod[dcb_pkg::PROD_W-1]
                               ? dcb_pkg::PROD_W'((1 << dcb_pkg::FRAC_W) - 1)
                               : dcb_pkg::PROD_W'(0));
  assign fb = prod_biased[dcb_pkg::FRAC_W +: dcb_pkg::ACC_W];
  assign y  = x - x_prev_r + fb;

  assign over  = !y[dcb_pkg::ACC_W-1] &&  (|y[dcb_pkg::ACC_W-2:dcb_pkg::SAMPLE_W-1]);
  assign under =  y[dcb_pkg::ACC_W-1] && !(&y[dcb_pkg::ACC_W-2:dcb_pkg::SAMPLE_W-1]);

  always_comb begin
    res.clipped = over || under;
    if (over) begin
      res.sample = {1'b0, {(dcb_pkg::SAMPLE_W-1){1'b1}}};
    end else if (under) begin
      res.sample = {1'b1, {(dcb_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      res.sample = y[dcb_pkg::SAMPLE_W-1:0];
    end
  end

  assign x_prev_nxt = fire ? x : x_prev_r;
  assign y_prev_nxt = fire ? y : y_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_prev_r <= '0;
      y_prev_r <= '0;
    end else begin
      x_prev_r <= x_prev_nxt;
      y_prev_r <= y_prev_nxt;
    end
  end

endmodule

>>> rtl/decimating_dc_blocking_filter.sv
// Top level of the decimating DC-blocking filter: config registers, input
// register, output register. Depends on dcb_pkg, dcb_accum, dcb_filter.
//
//   port group   direction   handshake            payload
//   in_          sink        in_valid/in_stall    in_raw_sample
//   out_         source      out_valid/out_stall  out_filtered_sample, out_clipped
//   cfg_         sink        cfg_we               cfg_index, cfg_data
//
// One sample per cycle sustained while the output is not stalled. The sample that
// closes a group passes the input register; its result is then registered in the
// output register. The y feedback loop does one multiply and add per group.
// Reset is synchronous, active low, and clears filter and group state.
// A stalled result holds the output register; the input register keeps
// taking beats as long as the output can advance or the input register is empty.
module decimating_dc_blocking_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dcb_pkg::SAMPLE_W-1:0] in_raw_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dcb_pkg::SAMPLE_W-1:0] out_filtered_sample,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [dcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [dcb_pkg::FACTOR_W-1:0]        factor_r, factor_nxt;
  logic signed [dcb_pkg::SHIFT_W-1:0]  gain_r, gain_nxt;
  logic                                s1_valid_r, s1_valid_nxt;
  logic signed [dcb_pkg::SAMPLE_W-1:0] s1_sample_r, s1_sample_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [dcb_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                                out_clipped_r, out_clipped_nxt;
  logic                                advance;
  logic                                fire;
  logic                                in_take;
  dcb_pkg::dcb_group_t                 grp;
  dcb_pkg::dcb_result_t                res;

  always_comb begin
    factor_nxt = factor_r;
    gain_nxt   = gain_r;
    if (cfg_we) begin
      case (cfg_index)
        dcb_pkg::REG_DECIM: factor_nxt = cfg_data[dcb_pkg::FACTOR_W-1:0];
        dcb_pkg::REG_GAIN:  gain_nxt   = $signed(cfg_data[dcb_pkg::SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Output register may load when empty or when its beat leaves
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign s1_sample_nxt = in_take ? in_raw_sample : s1_sample_r;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    if (advance) begin
      out_valid_nxt = fire && grp.close;
    end
    if (fire && grp.close) begin
      out_sample_nxt  = res.sample;
      out_clipped_nxt = res.clipped;
    end
  end

  dcb_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (s1_sample_r),
    .factor (factor_r),
    .gain   (gain_r),
    .grp    (grp)
  );

  dcb_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire && grp.close),
    .x     (grp.x),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r    <= dcb_pkg::FACTOR_RESET;
      gain_r      <= $signed(dcb_pkg::GAIN_RESET);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      factor_r    <= factor_nxt;
      gain_r      <= gain_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r   <= s1_sample_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_clipped         = out_clipped_r;

endmodule

>>> rtl/dcb_checker.sv
// Port-level checks for the decimating DC-blocking filter, bound to the top.
// Depends on dcb_pkg and decimating_dc_blocking_filter_macros.svh.
`include "decimating_dc_blocking_filter_macros.svh"

module dcb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dcb_pkg::SAMPLE_W-1:0] out_filtered_sample,
  input logic                                out_clipped
);

  // Stalled result beat holds
  `DCB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_filtered_sample) && $stable(out_clipped))

  // A clipped beat carries a rail value
  `DCB_ASSERT_IMPL(a_clip_rail, clk, rst_n, out_valid && out_clipped, out_filtered_sample == 16'sh7fff || out_filtered_sample == -16'sh8000)

  // Input backs up only behind a stalled result
  `DCB_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A new result follows an input beat that passed the input register
  `DCB_ASSERT_IMPL(a_rise_src, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

  // Output is empty right after reset
  `DCB_ASSERT_IMPL(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid)

endmodule

bind decimating_dc_blocking_filter dcb_checker u_dcb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_filtered_sample (out_filtered_sample),
  .out_clipped         (out_clipped)
);
